// ===== sv/npcs_pkg.sv =====
// Shared types and constants for the nearest palette color search block.
// No dependencies; imported by the controller, datapath and top level.
package npcs_pkg;

    localparam int COLOR_W         = 8;
    localparam int IN_INDEX_W      = 8;
    localparam int OUT_INDEX_W     = 8;
    localparam int DIST_W          = 18;
    localparam int SQ_W            = 2 * COLOR_W;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 32;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [DIST_W-1:0] NO_DISTANCE_YET = {DIST_W{1'b1}};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic wr;
        logic start;
        logic issue;
        logic publish;
    } npcs_cmd_t;

    typedef struct packed {
        logic addr_last;
        logic pipe_empty;
        logic out_free;
    } npcs_status_t;

endpackage

// ===== sv/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search block.
// Depends on npcs_pkg, npcs_ctrl and npcs_dp.
//
//  channel  | direction | content
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | palette write (tuser=0) or color query (tuser=1)
//  m_axis   | out       | best index and squared distance, one per query
//
// A query scans every palette entry, one per cycle through the single memory
// read port and distance pipeline, and its result is published once the
// pipeline has drained and the output register is free.
// Reset clears control state only; the palette is undefined until written.
// A result held by m_axis_tready low does not block writes; the next query
// result waits until the output register is free.
module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op[0]
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // best_index[7:0], best_distance[25:8], zero[31:26]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    npcs_cmd_t              cmd;
    npcs_status_t           status;
    logic [OUT_INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]      best_distance;

    npcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (op_t'(s_axis_tuser[0])),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    npcs_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (s_axis_tdata[7:0]),
        .red           (s_axis_tdata[15:8]),
        .green         (s_axis_tdata[23:16]),
        .blue          (s_axis_tdata[31:24]),
        .m_ready       (m_axis_tready),
        .m_valid       (m_axis_tvalid),
        .best_index    (best_index),
        .best_distance (best_distance)
    );

    assign m_axis_tdata = {{(M_TDATA_W - OUT_INDEX_W - DIST_W){1'b0}},
                           best_distance, best_index};

endmodule

// ===== sv/npcs_ctrl.sv =====
// Controller state machine for the nearest palette color search block.
// Depends on npcs_pkg; drives the datapath through npcs_cmd_t.
module npcs_ctrl
    import npcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  op_t          s_op,
    output logic         s_ready,
    input  npcs_status_t status,
    output npcs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_ready = ready_reg;
    assign accept  = s_valid && ready_reg;

    always_comb begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd.wr      = 1'b0;
        cmd.start   = 1'b0;
        cmd.issue   = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.wr    = accept && (s_op == OP_WRITE);
                cmd.start = accept && (s_op == OP_QUERY);
                if (cmd.start) begin
                    state_next = ST_SCAN;
                    ready_next = 1'b0;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (status.addr_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (status.pipe_empty && status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                    ready_next  = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== sv/npcs_dp.sv =====
// Datapath: palette memory, scan address counter, distance pipeline,
// best-match tracking and result register. Depends on npcs_pkg.
module npcs_dp
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  npcs_cmd_t              cmd,
    output npcs_status_t           status,
    input  logic [IN_INDEX_W-1:0]  entry_index,
    input  logic [COLOR_W-1:0]     red,
    input  logic [COLOR_W-1:0]     green,
    input  logic [COLOR_W-1:0]     blue,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [OUT_INDEX_W-1:0] best_index,
    output logic [DIST_W-1:0]      best_distance
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int ENT_W = 3 * COLOR_W;

    logic [ENT_W-1:0]   mem [PALETTE_ENTRIES];
    logic               wr_ok;

    logic [IDX_W-1:0]   addr_reg;
    logic [COLOR_W-1:0] q_r_reg, q_g_reg, q_b_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg, idx3_reg;
    logic [ENT_W-1:0]   rd_data_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]  dist_reg;

    logic [COLOR_W-1:0] d_r, d_g, d_b;
    logic [COLOR_W-1:0] e_r, e_g, e_b;

    logic [IDX_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;

    logic               out_valid_reg;
    logic [OUT_INDEX_W-1:0] out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;

    assign wr_ok = ({24'd0, entry_index} < 32'(PALETTE_ENTRIES));

    always_ff @(posedge aclk) begin
        if (cmd.wr && wr_ok) begin
            mem[IDX_W'(entry_index)] <= {red, green, blue};
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign e_r = rd_data_reg[ENT_W-1 -: COLOR_W];
    assign e_g = rd_data_reg[2*COLOR_W-1 -: COLOR_W];
    assign e_b = rd_data_reg[COLOR_W-1:0];
    assign d_r = (e_r > q_r_reg) ? (e_r - q_r_reg) : (q_r_reg - e_r);
    assign d_g = (e_g > q_g_reg) ? (e_g - q_g_reg) : (q_g_reg - e_g);
    assign d_b = (e_b > q_b_reg) ? (e_b - q_b_reg) : (q_b_reg - e_b);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_r_reg <= red;
            q_g_reg <= green;
            q_b_reg <= blue;
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        sq_r_reg <= SQ_W'(d_r * d_r);
        sq_g_reg <= SQ_W'(d_g * d_g);
        sq_b_reg <= SQ_W'(d_b * d_b);
        dist_reg <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        if (cmd.publish) begin
            out_index_reg <= OUT_INDEX_W'(best_idx_reg);
            out_dist_reg  <= best_dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= NO_DISTANCE_YET;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.start) begin
                addr_reg      <= '0;
                best_idx_reg  <= '0;
                best_dist_reg <= NO_DISTANCE_YET;
            end else begin
                if (cmd.issue) begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (v3_reg && (dist_reg < best_dist_reg)) begin
                    best_dist_reg <= dist_reg;
                    best_idx_reg  <= idx3_reg;
                end
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.addr_last  = (addr_reg == IDX_W'(PALETTE_ENTRIES - 1));
    assign status.pipe_empty = !(v1_reg || v2_reg || v3_reg);
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign best_index    = out_index_reg;
    assign best_distance = out_dist_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for nearest_palette_color_search: loads palette entries, queries
// colors and checks every returned index and squared distance against an own palette copy.
// Depends on npcs_pkg and the nearest_palette_color_search RTL.
module testbench;
    import npcs_pkg::*;

    localparam int ENTRIES      = PALETTE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 730;
    localparam int SCAN_SETTLE  = ENTRIES + 16;
    localparam int HOLD_CYCLES  = 3000;
    localparam int RUN_LIMIT    = 3_000_000;
    localparam int DIST_LSB     = OUT_INDEX_W;
    localparam int PAD_LSB      = OUT_INDEX_W + DIST_W;

    typedef struct {
        logic [OUT_INDEX_W-1:0] idx;
        logic [DIST_W-1:0]      sq_dist;
    } match_t;

    class palette_tracker;
        logic [3*COLOR_W-1:0] swatch [ENTRIES];
        match_t               expected_matches [$];
        int                   failures;
        int                   matches_seen;

        function new();
            foreach (swatch[i]) swatch[i] = '0;
            failures     = 0;
            matches_seen = 0;
        endfunction

        function int unsigned sq_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
            int unsigned gap;
            gap = (a > b) ? int'(a - b) : int'(b - a);
            return gap * gap;
        endfunction

        function match_t nearest_entry(logic [3*COLOR_W-1:0] color);
            match_t      m;
            int unsigned best;
            int unsigned d;
            best  = 32'h7fff_ffff;
            m.idx = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                d = sq_gap(swatch[i][23:16], color[23:16])
                  + sq_gap(swatch[i][15:8], color[15:8])
                  + sq_gap(swatch[i][7:0], color[7:0]);
                if (d < best) begin
                    best  = d;
                    m.idx = OUT_INDEX_W'(i);
                    if (d == 0)
                        break;
                end
            end
            m.sq_dist = DIST_W'(best);
            return m;
        endfunction

        function void note_item(op_t op, logic [IN_INDEX_W-1:0] idx,
                                logic [3*COLOR_W-1:0] color);
            if (op == OP_WRITE) begin
                if (int'(idx) < ENTRIES)
                    swatch[idx] = color;
            end else begin
                expected_matches.push_back(nearest_entry(color));
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on result %0d, %0s: got %0d, expected %0d",
                     matches_seen, what, got, want);
            failures++;
        endtask

        task check_match(logic [M_TDATA_W-1:0] word);
            match_t want;
            matches_seen++;
            if (expected_matches.size() == 0) begin
                report("result with no query outstanding", word, 0);
                return;
            end
            want = expected_matches.pop_front();
            if (word[OUT_INDEX_W-1:0] !== want.idx)
                report("best_index", word[OUT_INDEX_W-1:0], want.idx);
            if (word[PAD_LSB-1:DIST_LSB] !== want.sq_dist)
                report("best_distance", word[PAD_LSB-1:DIST_LSB], want.sq_dist);
            if (word[M_TDATA_W-1:PAD_LSB] !== '0)
                report("padding bits", word[M_TDATA_W-1:PAD_LSB], 0);
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    palette_tracker tracker;
    bit             src_steady = 1'b0;
    bit             sink_hold  = 1'b0;
    int             cycles     = 0;

    nearest_palette_color_search u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_item(op_t'(s_axis_tuser[0]), s_axis_tdata[IN_INDEX_W-1:0],
                                  {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                   s_axis_tdata[31:24]});
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_match(m_axis_tdata);
        end
    end

    task automatic send_item(op_t op, logic [IN_INDEX_W-1:0] idx,
                             logic [3*COLOR_W-1:0] color);
        while (!src_steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {color[7:0], color[15:8], color[23:16], idx};
        @(negedge aclk);
        while (!s_axis_tready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [COLOR_W-1:0] edge_level();
        logic [COLOR_W-1:0] levels [6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
        return levels[$urandom_range(5)];
    endfunction

    task automatic random_item();
        int                    pick;
        int                    src;
        logic [IN_INDEX_W-1:0] idx;
        logic [3*COLOR_W-1:0]  color;
        pick = $urandom_range(99);
        src  = $urandom_range(9);
        idx  = IN_INDEX_W'($urandom);
        if (pick < 55) begin
            if (src < 5)
                color = 24'($urandom);
            else if (src < 8)
                color = tracker.swatch[$urandom_range(ENTRIES - 1)];
            else
                color = {edge_level(), edge_level(), edge_level()};
            send_item(OP_WRITE, idx, color);
        end else begin
            if (src < 4)
                color = tracker.swatch[$urandom_range(ENTRIES - 1)];
            else if (src < 6)
                color = tracker.swatch[$urandom_range(ENTRIES - 1)]
                      ^ (24'h070707 & 24'($urandom));
            else if (src < 7)
                color = {edge_level(), edge_level(), edge_level()};
            else
                color = 24'($urandom);
            send_item(OP_QUERY, idx, color);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= (tracker.matches_seen >= 150 && tracker.matches_seen < 300)
                                 || ($urandom_range(99) >= 27);
        end
    end

    initial begin
        @(posedge aclk);
        while (tracker.matches_seen < 60)
            @(posedge aclk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold = 1'b0;
    end

    initial begin
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < ENTRIES; i++)
            send_item(OP_WRITE, IN_INDEX_W'(i), 24'h000000);
        send_item(OP_QUERY, 8'h00, 24'hffffff);
        send_item(OP_QUERY, 8'hff, 24'h000000);
        send_item(OP_WRITE, 8'hff, 24'hffffff);
        send_item(OP_QUERY, 8'h00, 24'hffffff);
        send_item(OP_QUERY, 8'h5a, 24'hfeffff);
        send_item(OP_WRITE, 8'd10, 24'h646464);
        send_item(OP_WRITE, 8'd20, 24'h646464);
        send_item(OP_QUERY, 8'h00, 24'h656464);
        send_item(OP_QUERY, 8'h00, 24'h646464);
        send_item(OP_WRITE, 8'h00, 24'hff0000);
        send_item(OP_WRITE, 8'h01, 24'h00ff00);
        send_item(OP_WRITE, 8'h02, 24'h0000ff);
        send_item(OP_QUERY, 8'h00, 24'hf00000);
        send_item(OP_QUERY, 8'h00, 24'h00f000);
        send_item(OP_QUERY, 8'h00, 24'h0000f0);
        send_item(OP_QUERY, 8'haa, 24'h555555);
        send_item(OP_QUERY, 8'h55, 24'h000000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            src_steady = (n >= 300 && n < 550);
            random_item();
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.expected_matches.size() != 0)
            @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);

        if (tracker.failures == 0 && tracker.expected_matches.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
